### rtl/gclp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclp_pkg: shared definitions of the gain command line parser
// Character codes, widths, result codes and the register map.
// ----------------------------------------------------------------------------
package gclp_pkg;

	// Longest accepted line, the '!' included.
	localparam int LINE_MAX   = 256;
	localparam int LINE_CNT_W = $clog2(LINE_MAX + 2);

	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 18;
	localparam int GAIN_W   = 10;
	localparam int LEN_W    = 3;
	localparam int LEN_SAT  = 7;
	// Field characters that a legal length of four to six can read.
	localparam int FIELD_DEPTH = 6;
	// Raw digit sum before saturation.
	localparam int SUM_W    = 24;
	localparam int DIGIT_W  = 10;

	localparam int VALUE_LIMIT = 99999;

	// Division by 100 of a value below 100000 as a reciprocal multiply.
	localparam int DIV100_MUL   = 167773;
	localparam int DIV100_MUL_W = 18;
	localparam int DIV100_SHIFT = 24;

	localparam logic [CHAR_W-1:0] CHAR_EQUALS = 8'h3D;
	localparam logic [CHAR_W-1:0] CHAR_END    = 8'h21;
	localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_P      = 8'h50;
	localparam logic [CHAR_W-1:0] CHAR_I      = 8'h49;
	localparam logic [CHAR_W-1:0] CHAR_D      = 8'h44;
	localparam logic [CHAR_W-1:0] TAG_RESET   = 8'h32;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_P    = 2'd1,
		TGT_I    = 2'd2,
		TGT_D    = 2'd3
	} target_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEN  = 2'd1,
		ST_NO_EQ    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// APB register map.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_TARGET_TAG = 1'b0;

endpackage

### rtl/gclp_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclp_byte_if: received character channel
// Valid/ready channel that carries one character per transfer.
// ----------------------------------------------------------------------------
interface gclp_byte_if;
	logic                         valid;
	logic                         ready;
	logic [gclp_pkg::CHAR_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/gclp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclp_result_if: parse result channel
// Valid/ready channel that carries one line result per transfer.
// ----------------------------------------------------------------------------
interface gclp_result_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          target;
	logic signed [gclp_pkg::VALUE_W-1:0] value_hundredths;
	logic [1:0]                          status;
	logic [gclp_pkg::GAIN_W-1:0]         gain_p;
	logic [gclp_pkg::GAIN_W-1:0]         gain_i;
	logic [gclp_pkg::GAIN_W-1:0]         gain_d;

	modport source (output valid, output target, output value_hundredths, output status,
		output gain_p, output gain_i, output gain_d, input ready);
	modport sink   (input valid, input target, input value_hundredths, input status,
		input gain_p, input gain_i, input gain_d, output ready);
endinterface

### rtl/gain_command_line_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_command_line_parser_top: PID gain command line parser
// Parses lines such as P2=12.34! into signed hundredths and loads gains.
// ----------------------------------------------------------------------------
// Throughput: one character transfer per cycle, '!' characters included, while
// the input is not stalled. The result of a line passes from the parse register
// (stage 1) to the result register (stage 2), where it is valid until taken.
// Characters stall only while both stages are full.
// Reset (arst_n low, asynchronous) clears the line state, the gains and both
// pipeline stages, and sets the target tag to '2'.
// ----------------------------------------------------------------------------
module gain_command_line_parser_top (
	input  logic                              clk,
	input  logic                              arst_n,
	gclp_byte_if.sink                         byte_in,
	gclp_result_if.source                     result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gclp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [gclp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [gclp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import gclp_pkg::*;

	// ------------------------------------------------------------------
	// Configuration register. Address bit 2 selects the register; only the
	// target tag exists, so every address with bit 2 set reads zero.
	// ------------------------------------------------------------------
	logic [CHAR_W-1:0] tag_q;
	logic              apb_wr;

	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= TAG_RESET;
		end else if (apb_wr && (paddr[2] == REG_TARGET_TAG)) begin
			tag_q <= pwdata[CHAR_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TARGET_TAG)
		? {{(APB_DATA_W-CHAR_W){1'b0}}, tag_q} : '0;

	// ------------------------------------------------------------------
	// Line state. Every accepted character updates it; a '!' ends the
	// line, hands the parse to stage 1 and clears the state.
	// ------------------------------------------------------------------
	logic                  in_acc;
	logic                  is_end;
	logic [CHAR_W-1:0]     c;
	logic [LINE_CNT_W-1:0] line_cnt_q;
	logic [LINE_CNT_W-1:0] line_cnt_inc;
	logic [CHAR_W-1:0]     first_q;
	logic [CHAR_W-1:0]     second_q;
	logic                  eq_seen_q;
	logic                  minus_q;
	logic [LEN_W-1:0]      len_q;
	logic [CHAR_W-1:0]     win_q [FIELD_DEPTH];

	logic                  s1_valid_q;
	logic                  s1_adv;
	logic                  out_valid_q;

	assign c      = byte_in.rx_byte;
	assign is_end = (c == CHAR_END);
	assign in_acc = byte_in.valid && byte_in.ready;

	// The count saturates one above the line limit so an overflow sticks.
	assign line_cnt_inc = (line_cnt_q <= LINE_CNT_W'(LINE_MAX))
		? line_cnt_q + LINE_CNT_W'(1) : line_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt_q <= '0;
			first_q    <= '0;
			second_q   <= '0;
			eq_seen_q  <= 1'b0;
			minus_q    <= 1'b0;
			len_q      <= '0;
		end else if (in_acc) begin
			if (is_end) begin
				line_cnt_q <= '0;
				first_q    <= '0;
				second_q   <= '0;
				eq_seen_q  <= 1'b0;
				minus_q    <= 1'b0;
				len_q      <= '0;
			end else begin
				line_cnt_q <= line_cnt_inc;
				if (line_cnt_q == '0) begin
					first_q <= c;
				end
				if (line_cnt_q == LINE_CNT_W'(1)) begin
					second_q <= c;
				end
				if (c == CHAR_EQUALS) begin
					// A later '=' restarts the field.
					eq_seen_q <= 1'b1;
					minus_q   <= 1'b0;
					len_q     <= '0;
				end else if (eq_seen_q) begin
					if (c == CHAR_MINUS && len_q == '0 && !minus_q) begin
						minus_q <= 1'b1;
					end else if (len_q != LEN_W'(LEN_SAT)) begin
						len_q <= len_q + LEN_W'(1);
					end
				end
			end
		end
	end

	// The field window is payload: the parse only reads entries that the
	// current field has written, so it needs neither reset nor clearing.
	always_ff @(posedge clk) begin
		if (in_acc && !is_end && c != CHAR_EQUALS && eq_seen_q
			&& !(c == CHAR_MINUS && len_q == '0 && !minus_q)) begin
			for (int k = FIELD_DEPTH - 1; k > 0; k--) begin
				win_q[k] <= win_q[k-1];
			end
			win_q[0] <= c;
		end
	end

	// ------------------------------------------------------------------
	// Parse of a finished line. The hundreds, tens and units digits sit
	// at fixed window places for every legal length; length five adds the
	// thousands digit and length six the thousands and ten-thousands digits.
	// ------------------------------------------------------------------
	logic [CHAR_W-1:0]        first_eff;
	logic [CHAR_W-1:0]        second_eff;
	logic                     overflow;
	logic                     len_ok;
	logic signed [DIGIT_W-1:0] dig [FIELD_DEPTH];
	logic signed [SUM_W-1:0]  raw_sum;
	logic signed [SUM_W-1:0]  signed_sum;
	logic signed [SUM_W-1:0]  sat_sum;
	target_t                  tgt_d;
	status_t                  status_d;
	logic signed [VALUE_W-1:0] value_d;

	assign first_eff  = (line_cnt_q == '0) ? c : first_q;
	assign second_eff = (line_cnt_q == LINE_CNT_W'(1)) ? c : second_q;
	assign overflow   = (line_cnt_inc > LINE_CNT_W'(LINE_MAX));
	assign len_ok     = len_q inside {LEN_W'(4), LEN_W'(5), LEN_W'(6)};

	always_comb begin
		for (int k = 0; k < FIELD_DEPTH; k++) begin
			dig[k] = $signed({{(DIGIT_W-CHAR_W){1'b0}}, win_q[k]})
				- $signed({{(DIGIT_W-CHAR_W){1'b0}}, CHAR_ZERO});
		end

		raw_sum = SUM_W'(dig[3]) * 24'sd100 + SUM_W'(dig[1]) * 24'sd10 + SUM_W'(dig[0]);
		if (len_q == LEN_W'(5) || len_q == LEN_W'(6)) begin
			raw_sum = raw_sum + SUM_W'(dig[4]) * 24'sd1000;
		end
		if (len_q == LEN_W'(6)) begin
			raw_sum = raw_sum + SUM_W'(dig[5]) * 24'sd10000;
		end
		if (!len_ok) begin
			raw_sum = '0;
		end

		signed_sum = minus_q ? -raw_sum : raw_sum;
		if (signed_sum > SUM_W'(VALUE_LIMIT)) begin
			sat_sum = SUM_W'(VALUE_LIMIT);
		end else if (signed_sum < -SUM_W'(VALUE_LIMIT)) begin
			sat_sum = -SUM_W'(VALUE_LIMIT);
		end else begin
			sat_sum = signed_sum;
		end

		tgt_d = TGT_NONE;
		if (second_eff == tag_q) begin
			case (first_eff)
				CHAR_P:  tgt_d = TGT_P;
				CHAR_I:  tgt_d = TGT_I;
				CHAR_D:  tgt_d = TGT_D;
				default: tgt_d = TGT_NONE;
			endcase
		end

		// Overflow wins over a missing '='; both report nothing else.
		if (overflow) begin
			status_d = ST_OVERFLOW;
			tgt_d    = TGT_NONE;
			value_d  = '0;
		end else if (!eq_seen_q) begin
			status_d = ST_NO_EQ;
			tgt_d    = TGT_NONE;
			value_d  = '0;
		end else begin
			status_d = len_ok ? ST_OK : ST_BAD_LEN;
			value_d  = VALUE_W'(sat_sum);
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: parsed line. It moves on when the result register is free or
	// being emptied, so a character can enter in every cycle unless stage 1 is held.
	// ------------------------------------------------------------------
	target_t                   tgt_s1;
	status_t                   status_s1;
	logic signed [VALUE_W-1:0] value_s1;

	assign s1_adv        = s1_valid_q && (!out_valid_q || result.ready);
	assign byte_in.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc && is_end) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && is_end) begin
			tgt_s1    <= tgt_d;
			status_s1 <= status_d;
			value_s1  <= value_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: gain update and result register. The integer part comes
	// from a reciprocal multiply; it is exact for values below 100000.
	// The gain registers only change as a result enters the result
	// register, so they serve directly as the gain fields of the result.
	// ------------------------------------------------------------------
	localparam int PROD_W = VALUE_W - 1 + DIV100_MUL_W;

	logic [PROD_W-1:0] div_prod;
	logic [GAIN_W-1:0] gain_new;
	logic [GAIN_W-1:0] gain_p_q;
	logic [GAIN_W-1:0] gain_i_q;
	logic [GAIN_W-1:0] gain_d_q;
	target_t           tgt_q;
	status_t           status_q;
	logic signed [VALUE_W-1:0] value_q;

	assign div_prod = PROD_W'(value_s1[VALUE_W-2:0]) * PROD_W'(DIV100_MUL);
	assign gain_new = (value_s1 > 0) ? div_prod[DIV100_SHIFT +: GAIN_W] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				case (tgt_s1)
					TGT_P:   gain_p_q <= gain_new;
					TGT_I:   gain_i_q <= gain_new;
					TGT_D:   gain_d_q <= gain_new;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tgt_q    <= tgt_s1;
			status_q <= status_s1;
			value_q  <= value_s1;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.target           = tgt_q;
	assign result.status           = status_q;
	assign result.value_hundredths = value_q;
	assign result.gain_p           = gain_p_q;
	assign result.gain_i           = gain_i_q;
	assign result.gain_d           = gain_d_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_end_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_end) |=> (s1_valid_q && line_cnt_q == '0 && !eq_seen_q))
		else $error("line end did not load stage 1 or clear the line state");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !result.ready) |-> !byte_in.ready)
		else $error("input taken while both stages are full and stalled");

	a_rejected_line_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status == ST_NO_EQ || result.status == ST_OVERFLOW))
		|-> (result.target == TGT_NONE && result.value_hundredths == '0))
		else $error("rejected line carries a target or a value");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_p_q <= GAIN_W'(999) && gain_i_q <= GAIN_W'(999) && gain_d_q <= GAIN_W'(999)))
		else $error("gain register above 999");

	a_gains_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=>
		($stable(gain_p_q) && $stable(gain_i_q) && $stable(gain_d_q)))
		else $error("gain changed while its result waits");

endmodule

### bench/gclp_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclp_line_checker: scoreboard of the gain command line parser
// Follows every character transfer and every write to the tag address, works
// out the result of each completed line and compares it with the result transfers.
// ----------------------------------------------------------------------------
module gclp_line_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	gclp_byte_if                            byte_mon,
	gclp_result_if                          res_mon,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [gclp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gclp_pkg::APB_DATA_W-1:0] pwdata,
	output int                              mismatch_count,
	output int                              lines_outstanding
);
	import gclp_pkg::*;

	localparam logic [APB_ADDR_W-1:0] TAG_ADDR = APB_ADDR_W'({REG_TARGET_TAG, 2'b00});
	localparam int WINDOW_DEPTH = 7;

	typedef struct packed {
		target_t                   tgt;
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
		logic [GAIN_W-1:0]         gain_p;
		logic [GAIN_W-1:0]         gain_i;
		logic [GAIN_W-1:0]         gain_d;
	} line_result_t;

	line_result_t            line_results_due[$];
	int                      err_total = 0;
	int                      due_count = 0;

	logic [CHAR_W-1:0]       tag_reg;
	logic [LINE_CNT_W-1:0]   chars_in_line;
	logic [CHAR_W-1:0]       lead_char;
	logic [CHAR_W-1:0]       tag_char;
	logic                    eq_seen;
	logic [CHAR_W-1:0]       field_chars [WINDOW_DEPTH];
	logic [LEN_W-1:0]        field_len;
	logic                    neg_field;
	logic [GAIN_W-1:0]       gain_reg [3];

	assign mismatch_count    = err_total;
	assign lines_outstanding = due_count;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		err_total++;
	endtask

	task automatic clear_field();
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			field_chars[i] = '0;
		end
		field_len = '0;
		neg_field = 1'b0;
	endtask

	task automatic clear_line_state();
		chars_in_line = '0;
		lead_char     = '0;
		tag_char      = '0;
		eq_seen       = 1'b0;
		clear_field();
	endtask

	// Value of the window entry idx, newest character at 0.
	function automatic int digit_val(input int idx);
		return int'(field_chars[idx]) - int'(CHAR_ZERO);
	endfunction

	// Signed hundredths of the field; the point position is never looked at.
	function automatic int field_hundredths();
		int v;
		case (field_len)
			3'd4: v = digit_val(3) * 100 + digit_val(1) * 10 + digit_val(0);
			3'd5: v = digit_val(4) * 1000 + digit_val(3) * 100 + digit_val(1) * 10
				+ digit_val(0);
			3'd6: v = digit_val(5) * 10000 + digit_val(4) * 1000 + digit_val(3) * 100
				+ digit_val(1) * 10 + digit_val(0);
			default: v = 0;
		endcase
		if (neg_field) v = -v;
		if (v > VALUE_LIMIT) v = VALUE_LIMIT;
		if (v < -VALUE_LIMIT) v = -VALUE_LIMIT;
		return v;
	endfunction

	task automatic parse_char(input logic [CHAR_W-1:0] c);
		line_result_t r;
		int           v;
		if (chars_in_line == 0) lead_char = c;
		else if (chars_in_line == 1) tag_char = c;
		if (chars_in_line <= LINE_MAX) chars_in_line++;

		if (c != CHAR_END) begin
			if (c == CHAR_EQUALS) begin
				// A later '=' starts the field over.
				eq_seen = 1'b1;
				clear_field();
			end else if (eq_seen) begin
				if (c == CHAR_MINUS && field_len == 0 && !neg_field) begin
					neg_field = 1'b1;
				end else begin
					for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
						field_chars[i] = field_chars[i-1];
					end
					field_chars[0] = c;
					if (field_len < LEN_SAT) field_len++;
				end
			end
		end else begin
			r.tgt    = TGT_NONE;
			r.value  = '0;
			r.status = ST_OK;
			if (chars_in_line > LINE_MAX) begin
				r.status = ST_OVERFLOW;
			end else if (!eq_seen) begin
				r.status = ST_NO_EQ;
			end else begin
				if (field_len < 4 || field_len > 6) r.status = ST_BAD_LEN;
				v       = field_hundredths();
				r.value = VALUE_W'(v);
				if (tag_char == tag_reg) begin
					case (lead_char)
						CHAR_P:  r.tgt = TGT_P;
						CHAR_I:  r.tgt = TGT_I;
						CHAR_D:  r.tgt = TGT_D;
						default: r.tgt = TGT_NONE;
					endcase
				end
				if (r.tgt != TGT_NONE) begin
					gain_reg[int'(r.tgt) - 1] = (v > 0) ? GAIN_W'(v / 100) : '0;
				end
			end
			r.gain_p = gain_reg[0];
			r.gain_i = gain_reg[1];
			r.gain_d = gain_reg[2];
			line_results_due.push_back(r);
			clear_line_state();
		end
	endtask

	task automatic check_result();
		line_result_t want;
		if (line_results_due.size() == 0) begin
			report_mismatch("result transfer with no line waiting for it");
		end else begin
			want = line_results_due.pop_front();
			if (res_mon.target !== want.tgt)
				report_mismatch($sformatf("target got %0d, expected %0d",
					res_mon.target, want.tgt));
			if (res_mon.value_hundredths !== want.value)
				report_mismatch($sformatf("value_hundredths got %0d, expected %0d",
					res_mon.value_hundredths, want.value));
			if (res_mon.status !== want.status)
				report_mismatch($sformatf("status got %0d, expected %0d",
					res_mon.status, want.status));
			if (res_mon.gain_p !== want.gain_p)
				report_mismatch($sformatf("gain_p got %0d, expected %0d",
					res_mon.gain_p, want.gain_p));
			if (res_mon.gain_i !== want.gain_i)
				report_mismatch($sformatf("gain_i got %0d, expected %0d",
					res_mon.gain_i, want.gain_i));
			if (res_mon.gain_d !== want.gain_d)
				report_mismatch($sformatf("gain_d got %0d, expected %0d",
					res_mon.gain_d, want.gain_d));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_results_due.delete();
			tag_reg = TAG_RESET;
			clear_line_state();
			for (int i = 0; i < 3; i++) begin
				gain_reg[i] = '0;
			end
		end else begin
			// Results come out only after their '!' has passed through stage 1, so the
			// comparison never needs the line that ends at this edge.
			if (res_mon.valid && res_mon.ready) check_result();
			if (byte_mon.valid && byte_mon.ready) parse_char(byte_mon.rx_byte);
			if (psel && penable && pwrite && pready && paddr == TAG_ADDR) begin
				tag_reg = pwdata[CHAR_W-1:0];
			end
		end
		due_count = line_results_due.size();
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the gain command line parser
// Feeds command lines, short and long, well formed and broken, through the
// character channel under several tag settings and flow control patterns,
// and leaves all checking to the line checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
	import gclp_pkg::*;

	localparam logic [APB_ADDR_W-1:0] TAG_ADDR = APB_ADDR_W'({REG_TARGET_TAG, 2'b00});
	// Characters of random lines sent in each phase.
	localparam int PHASE_CHARS   = 200;
	// Cycles that the result side holds off during the pressure phase.
	localparam int PRESSURE_HOLD = 400;
	// The slowest correct run stays far below this many cycles.
	localparam int CYCLE_LIMIT   = 200000;
	// Cycles waited after the last result.
	localparam int DRAIN_CYCLES  = 6;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int                    mismatches;
	int                    outstanding;
	int                    cycle_count = 0;

	// Flow control knobs: idle and stall chances in percent, and a hold-off request in cycles.
	int                    src_idle_pct = 0;
	int                    stall_pct = 0;
	int                    hold_cycles_req = 0;

	logic [CHAR_W-1:0]     cur_tag;
	logic [CHAR_W-1:0]     line_buf[$];
	int                    chars_sent = 0;

	gclp_byte_if   byte_if ();
	gclp_result_if res_if ();

	gain_command_line_parser_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	gclp_line_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_mon          (byte_if),
		.res_mon           (res_if),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.pready            (pready),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.mismatch_count    (mismatches),
		.lines_outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// The watchdog ends a run that hangs, for example when a result never comes.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The result side is driven by its own process. A hold-off request from the
	// stimulus keeps ready low for that many cycles; otherwise ready drops at
	// random with the current stall percentage.
	initial begin
		int hold_left;
		hold_left    = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles_req > 0) begin
				hold_left       = hold_cycles_req;
				hold_cycles_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Any character except the one that ends a line.
	function automatic logic [CHAR_W-1:0] any_but_end();
		logic [CHAR_W-1:0] c;
		do c = CHAR_W'($urandom_range(255)); while (c == CHAR_END);
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit();
		return CHAR_ZERO + CHAR_W'($urandom_range(9));
	endfunction

	// Mostly digits, with points, minus signs and arbitrary codes mixed in so
	// that non-digit characters land inside the parsed window.
	function automatic logic [CHAR_W-1:0] rand_field_char();
		case ($urandom_range(7))
			0:       return any_but_end();
			1:       return CHAR_MINUS;
			2:       return ".";
			default: return rand_digit();
		endcase
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_buf.push_back(s[i]);
		end
	endtask

	// Appends a numeric field of one to three integer digits, a point and two
	// decimals, the form that reaches the gain registers.
	task automatic push_number();
		int n_int;
		n_int = $urandom_range(1, 3);
		for (int i = 0; i < n_int; i++) begin
			line_buf.push_back(rand_digit());
		end
		line_buf.push_back(".");
		line_buf.push_back(rand_digit());
		line_buf.push_back(rand_digit());
	endtask

	task automatic compose_line();
		int kind;
		int n;
		line_buf.delete();
		kind = $urandom_range(99);
		if (kind < 70) begin
			// Well-formed command with random content.
			case ($urandom_range(3))
				0:       line_buf.push_back(CHAR_P);
				1:       line_buf.push_back(CHAR_I);
				2:       line_buf.push_back(CHAR_D);
				default: line_buf.push_back(any_but_end());
			endcase
			line_buf.push_back(($urandom_range(9) < 8) ? cur_tag : any_but_end());
			if ($urandom_range(9) == 0) begin
				// An earlier '=' whose field must be thrown away.
				line_buf.push_back(CHAR_EQUALS);
				line_buf.push_back(rand_field_char());
			end
			line_buf.push_back(CHAR_EQUALS);
			if ($urandom_range(2) == 0) line_buf.push_back(CHAR_MINUS);
			if ($urandom_range(7) == 0) begin
				n = $urandom_range(0, 9);
				for (int i = 0; i < n; i++) begin
					line_buf.push_back(rand_field_char());
				end
			end else begin
				push_number();
			end
		end else if (kind < 80) begin
			// No '=' anywhere in the line.
			n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++) begin
				line_buf.push_back(any_but_end());
				if (line_buf[$] == CHAR_EQUALS) line_buf[$] = CHAR_MINUS;
			end
		end else if (kind < 92) begin
			// Noise, heavy on the characters that the parser reacts to.
			n = $urandom_range(0, 10);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(3))
					0:       line_buf.push_back(CHAR_EQUALS);
					1:       line_buf.push_back(CHAR_MINUS);
					default: line_buf.push_back(any_but_end());
				endcase
			end
		end else begin
			// '=' standing in the command or tag position.
			if ($urandom_range(1) == 0) begin
				line_buf.push_back(CHAR_EQUALS);
				line_buf.push_back(($urandom_range(1) == 0) ? CHAR_EQUALS : cur_tag);
			end else begin
				line_buf.push_back(CHAR_P);
				line_buf.push_back(CHAR_EQUALS);
			end
			if ($urandom_range(1) == 0) line_buf.push_back(CHAR_MINUS);
			push_number();
		end
		line_buf.push_back(CHAR_END);
	endtask

	// A line of exactly total characters, '!' included, for the overflow check.
	task automatic compose_long_line(input int total);
		line_buf.delete();
		line_buf.push_back(CHAR_P);
		line_buf.push_back(cur_tag);
		while (line_buf.size() < total - 7) begin
			line_buf.push_back(any_but_end());
			if (line_buf[$] == CHAR_EQUALS) line_buf[$] = CHAR_ZERO;
		end
		push_text("=12.34!");
	endtask

	// One character transfer. It starts and ends at a falling edge, so valid
	// stays high between back-to-back transfers without being touched twice.
	task automatic send_char(input logic [CHAR_W-1:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_if.valid <= 1'b0;
			@(negedge clk);
		end
		byte_if.valid   <= 1'b1;
		byte_if.rx_byte <= c;
		do @(posedge clk); while (byte_if.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_buf[i]) begin
			send_char(line_buf[i]);
		end
		chars_sent += line_buf.size();
	endtask

	// Waits until every line has produced its result, then lets the block drain so
	// that nothing is still moving inside it.
	task automatic settle();
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// An APB write: setup cycle, then the access cycle that the block takes.
	task automatic write_tag(input logic [CHAR_W-1:0] t);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TAG_ADDR;
		pwdata  <= APB_DATA_W'(t);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_tag = t;
	endtask

	task automatic run_phase(input logic [CHAR_W-1:0] tag, input int src_pct,
		input int snk_pct, input int hold, input bit boundary_lines);
		int start;
		write_tag(tag);
		src_idle_pct    = src_pct;
		stall_pct       = snk_pct;
		hold_cycles_req = hold;
		if (boundary_lines) begin
			// The longest legal line and the first one that overflows.
			compose_long_line(LINE_MAX);
			send_line();
			compose_long_line(LINE_MAX + 1);
			send_line();
		end
		start = chars_sent;
		while (chars_sent - start < PHASE_CHARS) begin
			if ($urandom_range(149) == 0) begin
				compose_long_line($urandom_range(LINE_MAX - 2, LINE_MAX + 6));
			end else begin
				compose_line();
			end
			send_line();
		end
		byte_if.valid <= 1'b0;
		settle();
	endtask

	initial begin
		arst_n          = 1'b0;
		byte_if.valid   = 1'b0;
		byte_if.rx_byte = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		cur_tag         = TAG_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed lines under the reset tag: a lone '!', the largest value,
		// a negative value, a field that is too short framed by the extreme
		// codes, and the derivative gain with the negative value nearest zero.
		line_buf.delete();
		line_buf.push_back(CHAR_END);
		line_buf.push_back(CHAR_P);
		line_buf.push_back(TAG_RESET);
		push_text("=999.99!");
		line_buf.push_back(CHAR_I);
		line_buf.push_back(TAG_RESET);
		push_text("=-5.67!");
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h00);
		line_buf.push_back(CHAR_EQUALS);
		line_buf.push_back(CHAR_END);
		line_buf.push_back(CHAR_D);
		line_buf.push_back(TAG_RESET);
		push_text("=-0.01!");
		send_line();
		byte_if.valid <= 1'b0;
		settle();

		// Random phases, each under a new tag and a new flow control pattern.
		run_phase(8'hFF, 0, 0, 0, 1'b1);
		run_phase(8'h00, 62, 0, 0, 1'b0);
		run_phase(CHAR_P, 0, 62, 0, 1'b0);
		run_phase(CHAR_W'($urandom_range(255)), 9, 9, 0, 1'b0);
		// Pressure: the result side holds off while lines keep coming, so the
		// result pipeline fills and character transfers stall.
		run_phase(TAG_RESET, 0, 0, PRESSURE_HOLD, 1'b0);
		run_phase(CHAR_W'($urandom_range(255)), 62, 62, 0, 1'b0);

		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
